>>> src/osd_text_cursor_writer_core_defines.svh
// assertion macros shared by the cursor writer rtl
// depends on: a clk and an active-low arst_n in the including module
`ifndef OSD_TEXT_CURSOR_WRITER_CORE_DEFINES_SVH
`define OSD_TEXT_CURSOR_WRITER_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define OTCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define OTCW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> src/otcw_pkg.sv
// shared types, codes and the font lookup for the cursor writer
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none
package otcw_pkg;

	// default geometry
	localparam int DEF_COLUMNS  = 30;
	localparam int DEF_LAST_ROW = 15;

	// fixed row stride of the display memory
	localparam logic [8:0] ROW_STRIDE = 9'd30;

	// widths
	localparam int COL_W  = 5;
	localparam int ROW_W  = 4;
	localparam int ADDR_W = 9;

	// queue between front and back
	localparam int QDEPTH = 4;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_HOME  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// display register selects
	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_ADDR_HI = 2'd1;
	localparam logic [1:0] REG_ADDR_LO = 2'd2;
	localparam logic [1:0] REG_DATA_IN = 2'd3;

	// data bytes
	localparam logic [7:0] END_MARK  = 8'hFF;
	localparam logic [7:0] CLEAR_CMD = 8'h04;
	localparam logic [7:0] MODE_OFF  = 8'h00;
	localparam logic [7:0] ATTR_RST  = 8'h01;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] CHAR_CR   = 8'h0D;

	// write sequence steps of one character
	localparam logic [2:0] STEP_ATTR     = 3'd0;
	localparam logic [2:0] STEP_ADDR_HI  = 3'd1;
	localparam logic [2:0] STEP_ADDR_LO  = 3'd2;
	localparam logic [2:0] STEP_CODE     = 3'd3;
	localparam logic [2:0] STEP_END      = 3'd4;
	localparam logic [2:0] STEP_MODE_OFF = 3'd5;

	// queued command kinds
	typedef enum logic {
		CMD_CLEAR = 1'b0,
		CMD_CHAR  = 1'b1
	} cmd_t;

	// one queued command
	typedef struct packed {
		cmd_t              kind;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        code;
	} entry_t;

	// ascii to overlay font code, unmapped gives blank
	function automatic logic [7:0] font_code(input logic [7:0] c);
		logic [7:0] r;
		r = 8'h00;
		if (c == 8'd48)
			r = 8'h0a;
		else if (c > 8'd48 && c < 8'd58)
			r = c - 8'd48;
		else if (c > 8'd64 && c < 8'd91)
			r = c - 8'd54;
		else if (c > 8'd96 && c < 8'd123)
			r = c - 8'd60;
		else begin
			case (c)
				8'd34:   r = 8'h48;
				8'd39:   r = 8'h46;
				8'd40:   r = 8'h3f;
				8'd41:   r = 8'h40;
				8'd44:   r = 8'h45;
				8'd45:   r = 8'h49;
				8'd46:   r = 8'h41;
				8'd47:   r = 8'h47;
				8'd58:   r = 8'h44;
				8'd59:   r = 8'h43;
				8'd60:   r = 8'h4a;
				8'd62:   r = 8'h4b;
				8'd63:   r = 8'h42;
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/otcw_front.sv
// front end: accepts operations, keeps the cursor, classifies into commands
// depends on: otcw_pkg
`timescale 1ns / 1ps
`default_nettype none
module otcw_front #(
	parameter int COLUMNS  = otcw_pkg::DEF_COLUMNS,
	parameter int LAST_ROW = otcw_pkg::DEF_LAST_ROW
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire logic [1:0]       operation,
	input  wire logic [7:0]       char_code,
	output otcw_pkg::entry_t      wr_entry,
	output logic                  wr_en
);
	import otcw_pkg::*;

	logic [COL_W-1:0] col_q, col_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [ROW_W-1:0] row_next;
	logic             col_end;

	// wrapped row and line end
	assign row_next = (row_q >= ROW_W'(LAST_ROW)) ? '0 : row_q + 1'b1;
	assign col_end  = (col_q >= COL_W'(COLUMNS - 1));

	// classify and update cursor
	always_comb begin
		col_d         = col_q;
		row_d         = row_q;
		wr_en         = 1'b0;
		// command payload
		wr_entry.addr = ADDR_W'(row_q) * ROW_STRIDE + ADDR_W'(col_q);
		wr_entry.code = font_code(char_code);
		wr_entry.kind = CMD_CHAR;
		unique case (op_t'(operation))
			OP_PUT: begin
				if (char_code == CHAR_LF) begin
					row_d = row_next;
					col_d = '0;
				end else if (char_code == CHAR_CR) begin
					col_d = '0;
				end else begin
					wr_en = accept;
					if (col_end) begin
						col_d = '0;
						row_d = row_next;
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			OP_HOME: begin
				col_d = '0;
				row_d = '0;
			end
			OP_CLEAR: begin
				wr_en         = accept;
				wr_entry.kind = CMD_CLEAR;
				col_d         = '0;
				row_d         = '0;
			end
			default: begin
				col_d = col_q;
				row_d = row_q;
			end
		endcase
	end

	// cursor registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule
`default_nettype wire

>>> src/otcw_queue.sv
// short command queue between front and back
// depends on: otcw_pkg, assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "osd_text_cursor_writer_core_defines.svh"
module otcw_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  otcw_pkg::entry_t      wr_entry,
	output logic                  full,
	input  wire logic             rd_en,
	output otcw_pkg::entry_t      rd_entry,
	output logic                  rd_valid
);
	import otcw_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	entry_t           mem_q [QDEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_rd;

	// status
	assign full     = (count_q == (PTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rptr_q];
	assign do_rd    = rd_en && rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en)
				wptr_q <= (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (wr_en && !do_rd)
				count_q <= count_q + 1'b1;
			else if (!wr_en && do_rd)
				count_q <= count_q - 1'b1;
		end
	end

	`OTCW_NEVER(a_no_overflow, wr_en && full, "queue written while full")
	`OTCW_NEVER(a_count_range, count_q > (PTR_W+1)'(QDEPTH), "queue count out of range")

endmodule
`default_nettype wire

>>> src/otcw_back.sv
// back end: expands queued commands into display register words
// depends on: otcw_pkg, assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "osd_text_cursor_writer_core_defines.svh"
module otcw_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       attr,
	input  otcw_pkg::entry_t      hd_entry,
	input  wire logic             hd_valid,
	output logic                  hd_pop,
	output logic                  empty,
	input  wire logic             pop,
	output logic [1:0]            target_register,
	output logic [7:0]            write_data,
	output logic                  last_of_run
);
	import otcw_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic       load;
	logic [1:0] res_reg;
	logic [7:0] res_data;
	logic       res_last;
	logic       res_done;

	// output register frees when empty or being taken
	assign load   = !out_valid_q || pop;
	assign empty  = !out_valid_q;
	assign hd_pop = load && hd_valid && res_done;

	// word for the current step
	always_comb begin
		res_reg  = REG_MODE;
		res_data = CLEAR_CMD;
		res_last = 1'b1;
		res_done = 1'b1;
		if (hd_entry.kind == CMD_CHAR) begin
			res_last = 1'b0;
			res_done = 1'b0;
			unique case (step_q)
				STEP_ATTR: begin
					res_reg  = REG_MODE;
					res_data = attr;
				end
				STEP_ADDR_HI: begin
					res_reg  = REG_ADDR_HI;
					res_data = 8'(hd_entry.addr >> 8);
				end
				STEP_ADDR_LO: begin
					res_reg  = REG_ADDR_LO;
					res_data = hd_entry.addr[7:0];
				end
				STEP_CODE: begin
					res_reg  = REG_DATA_IN;
					res_data = hd_entry.code;
				end
				STEP_END: begin
					res_reg  = REG_DATA_IN;
					res_data = END_MARK;
				end
				STEP_MODE_OFF: begin
					res_reg  = REG_MODE;
					res_data = MODE_OFF;
					res_last = 1'b1;
					res_done = 1'b1;
				end
				default: begin
					res_reg  = REG_MODE;
					res_data = MODE_OFF;
					res_last = 1'b1;
					res_done = 1'b1;
				end
			endcase
		end
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_ATTR;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= hd_valid;
			if (hd_valid)
				step_q <= res_done ? STEP_ATTR : step_q + 1'b1;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (load && hd_valid) begin
			target_register <= res_reg;
			write_data      <= res_data;
			last_of_run     <= res_last;
		end
	end

	`OTCW_NEVER(a_step_range, step_q > STEP_MODE_OFF, "step counter out of range")
	`OTCW_NEVER(a_mid_run_head, step_q != STEP_ATTR && !(hd_valid && hd_entry.kind == CMD_CHAR),
		"character run lost its queue entry")
	`OTCW_ASSERT(a_stall_holds_step, (out_valid_q && !pop) |=> $stable(step_q),
		"step moved while output stalled")

endmodule
`default_nettype wire

>>> src/osd_text_cursor_writer_core.sv
// Text overlay cursor writer.
// Input side is a queue: present operation and char_code with push while full
// is low. Operation put character, home cursor or clear screen. Result side is
// a queue: while empty is low the oldest word (target_register, write_data,
// last_of_run) is shown and is taken with pop.
// A printable character gives six display register words, clear gives one,
// newline, carriage return and home only move the cursor and give none, the
// unused operation code changes nothing. The cursor is updated as the item is
// taken, so such items go in at one per cycle while full is low.
// The first word of an item passes through the command queue and then the output
// register before it shows. The back end sends one word per cycle while pop keeps
// up; a four-entry command queue lets the input run ahead while words wait.
// A stalled pop holds the current word and the back end; the input stalls
// only once the command queue fills.
// cfg_we/cfg_wdata write the attribute byte (reset 1), to be written when idle.
// Reset clears the cursor to the top left, empties the queue and the output.
// depends on: otcw_pkg, otcw_front, otcw_queue, otcw_back
`timescale 1ns / 1ps
`default_nettype none
module osd_text_cursor_writer_core #(
	parameter int COLUMNS  = otcw_pkg::DEF_COLUMNS,
	parameter int LAST_ROW = otcw_pkg::DEF_LAST_ROW
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       push,
	output logic            full,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] char_code,
	output logic            empty,
	input  wire logic       pop,
	output logic [1:0]      target_register,
	output logic [7:0]      write_data,
	output logic            last_of_run
);
	import otcw_pkg::*;

	logic   [7:0] attr_q;
	logic         accept;
	logic         q_wr;
	entry_t       q_wentry;
	entry_t       q_hd;
	logic         q_valid;
	logic         q_pop;

	assign accept = push && !full;

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			attr_q <= ATTR_RST;
		else if (cfg_we)
			attr_q <= cfg_wdata;
	end

	otcw_front #(
		.COLUMNS  (COLUMNS),
		.LAST_ROW (LAST_ROW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.char_code (char_code),
		.wr_entry  (q_wentry),
		.wr_en     (q_wr)
	);

	otcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_entry (q_wentry),
		.full     (full),
		.rd_en    (q_pop),
		.rd_entry (q_hd),
		.rd_valid (q_valid)
	);

	otcw_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.attr            (attr_q),
		.hd_entry        (q_hd),
		.hd_valid        (q_valid),
		.hd_pop          (q_pop),
		.empty           (empty),
		.pop             (pop),
		.target_register (target_register),
		.write_data      (write_data),
		.last_of_run     (last_of_run)
	);

endmodule
`default_nettype wire
